[rtl/core/arpc_pkg.sv]
// ---------------------------------------------------------------------------
// ARP cache package
// Shared widths, result codes and controller interface types for the
// address-resolution cache.
// ---------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int IP_W  = 32;
    localparam int MAC_W = 48;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_MISS  = 2'd1,
        ST_ADDED = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic start;
        logic read;
        logic commit;
    } arpc_cmd_t;

    typedef struct packed {
        logic hit;
        logic pend;
        logic ptr_end;
        logic out_free;
    } arpc_stat_t;

endpackage

`default_nettype wire

[rtl/core/arp_cache_table.sv]
// A miss searches every filled entry; a hit ends the search at its entry.
// One entry is read per cycle during the search. A new item is accepted
// only after the previous item's result has been committed.
// A result still waiting on m_tready holds back the commit of the next item.
// Reset clears the fill count and the handshake state; the entry memories
// are not cleared and are only read once written.
// ---------------------------------------------------------------------------
// ARP cache table
// IPv4-to-MAC cache with lookup and learn items over a linear entry search.
// ---------------------------------------------------------------------------
`default_nettype none

module arp_cache_table
    import arpc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // ip_addr[31:0], mac_addr[79:32]
    input  wire logic        s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // mac_out[47:0]
    output logic [1:0]       m_tuser    // status[1:0]
);

    arpc_cmd_t  cmd;
    arpc_stat_t st;

    arpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    arpc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .st         (st),
        .in_mode    (s_tuser),
        .in_ip      (s_tdata[IP_W-1:0]),
        .in_mac     (s_tdata[IP_W+MAC_W-1:IP_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_mac    (m_tdata)
    );

endmodule

`default_nettype wire

[rtl/core/arpc_ctrl.sv]
// ---------------------------------------------------------------------------
// ARP cache controller
// Sequences the accept, the entry-by-entry search and the result commit.
// ---------------------------------------------------------------------------
`default_nettype none

module arpc_ctrl
    import arpc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire arpc_stat_t st,
    output arpc_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (st.hit || (st.ptr_end && !st.pend)) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.read = !st.ptr_end;
                end
            end
            S_FINISH: begin
                if (st.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/arpc_dp.sv]
// ---------------------------------------------------------------------------
// ARP cache datapath
// Entry memories, search pointer, compare stage, fill count and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module arpc_dp
    import arpc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire arpc_cmd_t        cmd,
    output arpc_stat_t            st,
    input  wire logic             in_mode,
    input  wire logic [IP_W-1:0]  in_ip,
    input  wire logic [MAC_W-1:0] in_mac,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [1:0]            out_status,
    output logic [MAC_W-1:0]      out_mac
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [IP_W-1:0]  ip_mem  [TABLE_DEPTH];
    logic [MAC_W-1:0] mac_mem [TABLE_DEPTH];

    logic             mode_reg;
    logic [IP_W-1:0]  key_ip_reg;
    logic [MAC_W-1:0] key_mac_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [IP_W-1:0]  ip_rd_reg;
    logic [MAC_W-1:0] mac_rd_reg;
    logic             found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [MAC_W-1:0] hit_mac_reg;
    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [MAC_W-1:0] out_mac_reg;

    logic             hit;
    logic             full;
    logic             wr_en;
    logic             wr_new;
    logic [IDX_W-1:0] wr_idx;
    status_t          res_status;

    assign hit         = pend_reg && (ip_rd_reg == key_ip_reg);
    assign full        = (count_reg == CNT_W'(TABLE_DEPTH));
    assign wr_en       = cmd.commit && mode_reg && (found_reg || !full);
    assign wr_new      = !found_reg;
    assign wr_idx      = found_reg ? hit_idx_reg : count_reg[IDX_W-1:0];

    assign st.hit      = hit;
    assign st.pend     = pend_reg;
    assign st.ptr_end  = (ptr_reg == count_reg);
    assign st.out_free = !out_valid_reg || out_ready;

    always_comb begin
        if (!mode_reg) begin
            res_status = found_reg ? ST_FOUND : ST_MISS;
        end else if (found_reg) begin
            res_status = ST_FOUND;
        end else begin
            res_status = full ? ST_FULL : ST_ADDED;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            ip_rd_reg  <= ip_mem[ptr_reg[IDX_W-1:0]];
            mac_rd_reg <= mac_mem[ptr_reg[IDX_W-1:0]];
        end
        if (wr_en) begin
            mac_mem[wr_idx] <= key_mac_reg;
            if (wr_new) begin
                ip_mem[wr_idx] <= key_ip_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            mode_reg    <= in_mode;
            key_ip_reg  <= in_ip;
            key_mac_reg <= in_mac;
        end
        if (cmd.read) begin
            cmp_idx_reg <= ptr_reg[IDX_W-1:0];
        end
        if (hit) begin
            hit_idx_reg <= cmp_idx_reg;
            hit_mac_reg <= mac_rd_reg;
        end
        if (cmd.commit) begin
            out_status_reg <= res_status;
            out_mac_reg    <= (!mode_reg && found_reg) ? hit_mac_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.read;
            if (cmd.start) begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end else begin
                if (cmd.read) begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
                if (hit) begin
                    found_reg <= 1'b1;
                end
            end
            if (wr_en && wr_new) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_mac    = out_mac_reg;

endmodule

`default_nettype wire

[rtl/core/arpc_checker.sv]
// ---------------------------------------------------------------------------
// ARP cache port checker
// Port-level properties of the cache, attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module arpc_checker
    import arpc_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Only a found result may carry a nonzero MAC.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_FOUND) |-> (m_tdata == '0))
        else $error("nonzero MAC on a result that is not a hit");

    // The block takes one item at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // No result appears in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind arp_cache_table arpc_checker u_arpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
